// ----- rtl/pfa_pkg.sv -----
`default_nettype none

package pfa_pkg;

  localparam int unsigned SUM_BITS = 48;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    REG_TARGET_X    = 2'd0,
    REG_TARGET_Y    = 2'd1,
    REG_TARGET_Z    = 2'd2,
    REG_TARGET_MASS = 2'd3
  } pfa_reg_e;

  typedef struct packed {
    logic [SUM_BITS-1:0] quot;
    logic                clamped;
  } pfa_div_res_t;

endpackage

`default_nettype wire

// ----- rtl/pairwise_force_accumulator_unit.sv -----
// One neighbor at a time: the bit-serial squares and mass product come first, then the
// radix-2 divider; a zero-distance item skips the divider.
// The result for a last item appears in the cycle after the accumulate step.
// Reset (asynchronous, active low) clears the target registers, the sum and both flags.
`default_nettype none

module pairwise_force_accumulator_unit #(
  parameter int unsigned COORD_BITS     = 24,
  parameter int unsigned QUOT_FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire pfa_pkg::pfa_reg_e         cfg_index_i,
  input  wire logic [COORD_BITS-1:0]     cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [COORD_BITS-1:0]     nbr_x_i,
  input  wire logic [COORD_BITS-1:0]     nbr_y_i,
  input  wire logic [COORD_BITS-1:0]     nbr_z_i,
  input  wire logic [COORD_BITS-1:0]     nbr_mass_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [pfa_pkg::SUM_BITS-1:0]   force_sum_o,
  output logic                           saturated_o,
  output logic                           zero_distance_o
);
  import pfa_pkg::*;

  localparam int unsigned NUM_BITS  = 2 * COORD_BITS + QUOT_FRAC_BITS;
  localparam int unsigned DIST_BITS = 2 * COORD_BITS + 2;
  localparam int unsigned MM_BITS   = 2 * COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_ACC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [COORD_BITS-1:0] tx_q, ty_q, tz_q, tm_q;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic                  sat_q, sat_d;
  logic                  zero_q, zero_d;
  logic                  last_q, last_d;
  logic                  skip_q, skip_d;
  logic                  out_valid_q, out_valid_d;
  logic [SUM_BITS-1:0]   out_sum_q;
  logic                  out_sat_q, out_zero_q;
  logic                  out_load;

  logic                  in_accept;
  logic [COORD_BITS-1:0] dx, dy, dz;
  logic                  mul_done;
  logic [DIST_BITS-1:0]  dist2;
  logic [MM_BITS-1:0]    mm;
  logic                  div_start, div_done;
  pfa_div_res_t          div_res;
  logic [SUM_BITS:0]     sum_add;
  logic [SUM_BITS-1:0]   term, sum_new;
  logic                  sat_new, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q <= '0;
      ty_q <= '0;
      tz_q <= '0;
      tm_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TARGET_X:    tx_q <= cfg_data_i;
        REG_TARGET_Y:    ty_q <= cfg_data_i;
        REG_TARGET_Z:    tz_q <= cfg_data_i;
        REG_TARGET_MASS: tm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx = (nbr_x_i >= tx_q) ? nbr_x_i - tx_q : tx_q - nbr_x_i;
    dy = (nbr_y_i >= ty_q) ? nbr_y_i - ty_q : ty_q - nbr_y_i;
    dz = (nbr_z_i >= tz_q) ? nbr_z_i - tz_q : tz_q - nbr_z_i;
  end

  pfa_sqmul #(
    .COORD_BITS(COORD_BITS)
  ) u_sqmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .dx_i    (dx),
    .dy_i    (dy),
    .dz_i    (dz),
    .tmass_i (tm_q),
    .nmass_i (nbr_mass_i),
    .done_o  (mul_done),
    .dist2_o (dist2),
    .mm_o    (mm)
  );

  pfa_div #(
    .COORD_BITS    (COORD_BITS),
    .QUOT_FRAC_BITS(QUOT_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NUM_BITS'(mm) << QUOT_FRAC_BITS),
    .den_i   (dist2),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    term    = skip_q ? '0 : div_res.quot;
    sum_add = {1'b0, sum_q} + {1'b0, term};
    sum_new = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    sat_new = sat_q | (!skip_q && div_res.clamped) | sum_add[SUM_BITS];
    out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    zero_d      = zero_q;
    last_d      = last_q;
    skip_d      = skip_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d  = last_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (dist2 == '0) begin
            zero_d  = 1'b1;
            skip_d  = 1'b1;
            state_d = ST_ACC;
          end else begin
            skip_d    = 1'b0;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last_q) begin
          sum_d   = sum_new;
          sat_d   = sat_new;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          sum_d       = '0;
          sat_d       = 1'b0;
          zero_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      zero_q      <= 1'b0;
      last_q      <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      zero_q      <= zero_d;
      last_q      <= last_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q  <= sum_new;
      out_sat_q  <= sat_new;
      out_zero_q <= zero_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign force_sum_o     = out_sum_q;
  assign saturated_o     = out_sat_q;
  assign zero_distance_o = out_zero_q;

  a_mul_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside the multiply phase");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_no_div_on_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !skip_q)
    else $error("division started for a zero-distance neighbor");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_q == '0) && !sat_q && !zero_q && out_valid_o)
    else $error("accumulator not cleared after a result transaction was loaded");

endmodule

`default_nettype wire

// ----- rtl/pfa_sqmul.sv -----
`default_nettype none

module pfa_sqmul #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [COORD_BITS-1:0]     dx_i,
  input  wire logic [COORD_BITS-1:0]     dy_i,
  input  wire logic [COORD_BITS-1:0]     dz_i,
  input  wire logic [COORD_BITS-1:0]     tmass_i,
  input  wire logic [COORD_BITS-1:0]     nmass_i,
  output logic                           done_o,
  output logic [2*COORD_BITS+1:0]        dist2_o,
  output logic [2*COORD_BITS-1:0]        mm_o
);

  localparam int unsigned DIST_BITS = 2 * COORD_BITS + 2;
  localparam int unsigned MM_BITS   = 2 * COORD_BITS;
  localparam int unsigned CNT_W     = $clog2(COORD_BITS);

  logic [COORD_BITS-1:0] dx_q, dy_q, dz_q, tm_q;
  logic [COORD_BITS-1:0] xs_q, ys_q, zs_q, ms_q;
  logic [DIST_BITS-1:0]  dist_q, dist_d;
  logic [MM_BITS-1:0]    mm_q, mm_d;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [DIST_BITS-1:0]  add_x, add_y, add_z;
  logic [MM_BITS-1:0]    add_m;

  // Horner form, multiplier bits taken most significant first.
  always_comb begin
    add_x  = xs_q[COORD_BITS-1] ? DIST_BITS'(dx_q) : '0;
    add_y  = ys_q[COORD_BITS-1] ? DIST_BITS'(dy_q) : '0;
    add_z  = zs_q[COORD_BITS-1] ? DIST_BITS'(dz_q) : '0;
    add_m  = ms_q[COORD_BITS-1] ? MM_BITS'(tm_q) : '0;
    dist_d = (dist_q << 1) + add_x + add_y + add_z;
    mm_d   = (mm_q << 1) + add_m;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q   <= dx_i;
      dy_q   <= dy_i;
      dz_q   <= dz_i;
      tm_q   <= tmass_i;
      xs_q   <= dx_i;
      ys_q   <= dy_i;
      zs_q   <= dz_i;
      ms_q   <= nmass_i;
      dist_q <= '0;
      mm_q   <= '0;
    end else if (busy_q) begin
      xs_q   <= xs_q << 1;
      ys_q   <= ys_q << 1;
      zs_q   <= zs_q << 1;
      ms_q   <= ms_q << 1;
      dist_q <= dist_d;
      mm_q   <= mm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(COORD_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign dist2_o = dist_q;
  assign mm_o    = mm_q;

endmodule

`default_nettype wire

// ----- rtl/pfa_div.sv -----
`default_nettype none

module pfa_div #(
  parameter int unsigned COORD_BITS     = 24,
  parameter int unsigned QUOT_FRAC_BITS = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic [2*COORD_BITS+QUOT_FRAC_BITS-1:0]    num_i,
  input  wire logic [2*COORD_BITS+1:0]                   den_i,
  output logic                                           done_o,
  output pfa_pkg::pfa_div_res_t                          res_o
);
  import pfa_pkg::*;

  localparam int unsigned NUM_BITS = 2 * COORD_BITS + QUOT_FRAC_BITS;
  localparam int unsigned DEN_BITS = 2 * COORD_BITS + 2;
  localparam int unsigned CNT_W    = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] num_q;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [DEN_BITS:0]   rem_sh;
  logic [SUM_BITS-1:0] quot_q;
  logic                big_q, big_d;
  logic                qbit;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;

  // Restoring division, one quotient bit per cycle. A set bit at or above
  // the sum width means the term saturates.
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_BITS-1]};
    qbit   = rem_sh >= {1'b0, den_q};
    rem_d  = qbit ? DEN_BITS'(rem_sh - {1'b0, den_q}) : DEN_BITS'(rem_sh);
    big_d  = big_q | (qbit && (32'(cnt_q) >= 32'(SUM_BITS)));
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      big_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= num_q << 1;
      rem_q  <= rem_d;
      quot_q <= {quot_q[SUM_BITS-2:0], qbit};
      big_q  <= big_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o        = done_q;
  assign res_o.quot    = big_q ? SUM_MAX : quot_q;
  assign res_o.clamped = big_q;

endmodule

`default_nettype wire
